>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons))

`endif

>>> hw/rtl/stkr_pkg.sv
// ----------------------------------------------------------------------------
// stkr_pkg
// Request and status codes and the per-cell control bundle of the stack.
// ----------------------------------------------------------------------------
package stkr_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_REMOVE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Per-cell update command
  typedef struct packed {
    logic load;   // capture the request key
    logic shift;  // take the neighbor's entry from above
  } cell_ctrl_t;

endpackage

>>> hw/rtl/stkr_if.sv
// ----------------------------------------------------------------------------
// stkr_if
// Valid/ready channels carrying stack requests and stack results.
// ----------------------------------------------------------------------------
interface stkr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface stkr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [63:0] data;
  logic [3:0]  occupancy;

  modport source (output valid, output status, output found, output data,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input found, input data,
                  input occupancy, output ready);
endinterface

>>> hw/rtl/stkr_cell.sv
// ----------------------------------------------------------------------------
// stkr_cell
// One stack slot: holds a key, compares it to the request key and either
// loads the request key or takes the entry of the slot above.
// ----------------------------------------------------------------------------
module stkr_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                  clk_i,
  input  stkr_pkg::cell_ctrl_t  ctrl_i,
  input  logic                  occupied_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [KEY_BITS-1:0]   upper_i,
  output logic [KEY_BITS-1:0]   entry_o,
  output logic                  match_o
);
  import stkr_pkg::*;

  logic [KEY_BITS-1:0] entry_q;
  logic [KEY_BITS-1:0] entry_d;

  // Next entry: push load wins, else compaction shift, else hold
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = key_i;
    end else if (ctrl_i.shift) begin
      entry_d = upper_i;
    end
  end

  // Payload storage, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = occupied_i && (entry_q == key_i);

endmodule

>>> hw/rtl/stack_with_keyed_removal_unit.sv
// ----------------------------------------------------------------------------
// stack_with_keyed_removal_unit
// Bounded LIFO stack of keys with push, pop, search and keyed removal.
// ----------------------------------------------------------------------------
// The stack is a row of DEPTH cells, cell 0 at the bottom, each comparing its
// key to the request in parallel. The result of a request is registered and
// shows on the response channel the cycle after the request is taken. A new
// request is taken whenever the result register is empty or being drained,
// so with an always-ready sink the unit sustains one request per clock; the
// limit is the single result register. Removal drops the topmost matching
// entry and every cell above it takes its upper neighbor's key in the same
// cycle. Only the low KEY_BITS bits of a key are stored and compared; data is
// zero-extended to 64 bits.
// ----------------------------------------------------------------------------
module stack_with_keyed_removal_unit #(
  parameter int unsigned DEPTH    = 8,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  stkr_req_if.sink      req_i,
  stkr_rsp_if.source    rsp_o
);
  import stkr_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count_q, count_d;
  logic                 rsp_valid_q;
  status_e              status_q, status_d;
  logic                 found_q, found_d;
  logic [63:0]          data_q, data_d;
  logic [3:0]           occ_q;

  logic                 accept;
  logic [KEY_BITS-1:0]  key_k;
  logic [KEY_BITS-1:0]  entry   [DEPTH];
  cell_ctrl_t           ctrl    [DEPTH];
  logic [DEPTH-1:0]     match_vec;
  logic [DEPTH-1:0]     above_vec;
  logic [DEPTH-1:0]     top_sel;
  logic [DEPTH-1:0]     second_sel;
  logic [DEPTH-1:0]     push_sel;
  logic                 any_match;
  logic                 top_match;
  logic                 full;
  logic                 empty;
  logic                 do_push;
  logic                 do_remove;
  logic [KEY_BITS-1:0]  top_key;
  logic [KEY_BITS-1:0]  second_key;

  // Handshake: take a request while the result slot is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign key_k       = req_i.key[KEY_BITS-1:0];

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // Cell row
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [KEY_BITS-1:0] upper;

    if (gi == DEPTH - 1) begin : g_top
      assign upper = entry[gi];
    end else begin : g_mid
      assign upper = entry[gi+1];
    end

    // Position decodes against the fill count
    assign top_sel[gi]    = ((gi + 1) == int'(count_q));
    assign second_sel[gi] = ((gi + 2) == int'(count_q));
    assign push_sel[gi]   = (gi == int'(count_q));
    assign above_vec[gi]  = |(match_vec >> (gi + 1));

    assign ctrl[gi].load  = do_push && push_sel[gi];
    assign ctrl[gi].shift = do_remove && !above_vec[gi];

    stkr_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[gi]),
      .occupied_i (gi < int'(count_q)),
      .key_i      (key_k),
      .upper_i    (upper),
      .entry_o    (entry[gi]),
      .match_o    (match_vec[gi])
    );
  end

  assign any_match = |match_vec;
  assign top_match = |(match_vec & top_sel);

  // Top and next-to-top keys by AND-OR over the row
  always_comb begin
    top_key    = '0;
    second_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      top_key    = top_key    | (entry[i] & {KEY_BITS{top_sel[i]}});
      second_key = second_key | (entry[i] & {KEY_BITS{second_sel[i]}});
    end
  end

  // Request decode and result
  always_comb begin
    count_d   = count_q;
    status_d  = ST_OK;
    found_d   = 1'b0;
    data_d    = 64'(top_key);
    do_push   = 1'b0;
    do_remove = 1'b0;
    case (req_type_e'(req_i.req_type))
      REQ_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_push = accept;
          count_d = count_q + CW'(1);
          data_d  = 64'(key_k);
        end
      end
      REQ_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
          data_d   = '0;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      REQ_SEARCH: begin
        found_d  = any_match;
        status_d = any_match ? ST_OK : ST_NOT_FOUND;
      end
      REQ_REMOVE: begin
        if (any_match) begin
          found_d   = 1'b1;
          do_remove = accept;
          count_d   = count_q - CW'(1);
          data_d    = top_match ? 64'(second_key) : 64'(top_key);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Fill count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= found_d;
      data_q   <= data_d;
      occ_q    <= 4'(count_d);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.found     = found_q;
  assign rsp_o.data      = data_q;
  assign rsp_o.occupancy = occ_q;

endmodule

>>> hw/rtl/stkr_checker.sv
// ----------------------------------------------------------------------------
// stkr_checker
// Port-level checks of the stack unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stkr_checker #(
  parameter int unsigned DEPTH = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic        rsp_found_i,
  input logic [63:0] rsp_data_i,
  input logic [3:0]  rsp_occupancy_i
);
  import stkr_pkg::*;

  // A stalled result holds
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i) && $stable(rsp_status_i))

  // Every accepted request yields a result the next cycle
  `ASSERT_NEXT(a_req_to_rsp, clk_i, rst_ni, req_valid_i && req_ready_i, rsp_valid_i)

  // Empty pop reports no data and no entries
  `ASSERT_CLK(a_empty_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i == ST_EMPTY) |-> (rsp_data_i == 64'd0) && (rsp_occupancy_i == 4'd0))

  // A hit is always reported as ok
  `ASSERT_CLK(a_found_ok, clk_i, rst_ni, rsp_valid_i && rsp_found_i |-> (rsp_status_i == ST_OK))

  // Full push leaves the stack at capacity
  `ASSERT_CLK(a_full_occ, clk_i, rst_ni, rsp_valid_i && (rsp_status_i == ST_FULL) |-> (rsp_occupancy_i == 4'(DEPTH)))

endmodule

bind stack_with_keyed_removal_unit stkr_checker #(
  .DEPTH (DEPTH)
) u_stkr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_found_i     (rsp_o.found),
  .rsp_data_i      (rsp_o.data),
  .rsp_occupancy_i (rsp_o.occupancy)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed-removal stack. A queue of requests
// (directed corner cases, then random traffic) feeds a falling-edge driver.
// A rising-edge monitor models the stack for every accepted request and
// checks each response field against the oldest prediction. Both sides
// throttle at random, except for one window with no throttling.
// ----------------------------------------------------------------------------
module testbench;
  import stkr_pkg::*;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned KEY_BITS     = 64;
  localparam logic [63:0] KEY_MASK     = {64{1'b1}} >> (64 - KEY_BITS);
  localparam int          IDLE_PCT     = 34;
  localparam int          RANDOM_ITEMS = 1350;
  localparam int          CALM_FROM    = 1000;
  localparam int          CALM_TO      = 1600;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          DRAIN_CYCLES = 10;

  typedef struct packed {
    req_type_e   op;
    logic [63:0] key;
  } stack_request_t;

  typedef struct packed {
    status_e     status;
    logic        found;
    logic [63:0] data;
    logic [3:0]  occupancy;
  } stack_result_t;

  logic clk_i;
  logic rst_ni;

  stkr_req_if req_ch ();
  stkr_rsp_if rsp_ch ();

  stack_request_t pending_reqs[$];
  stack_result_t  expected_results[$];

  // Shadow copy of the stack contents
  logic [63:0] model_keys [DEPTH];
  int          model_fill;

  int   mismatches;
  int   cycle_count;
  int   stall_cycles;
  logic out_of_reset;
  logic req_taken;
  logic calm;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  stack_with_keyed_removal_unit #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Clock, period 8
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  task automatic flag_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Stack behavior for one request; updates the shadow state
  function automatic stack_result_t predict_stack(req_type_e op, logic [63:0] raw_key);
    stack_result_t res;
    logic [63:0]   key;
    int            hit;
    int            i;
    key        = raw_key & KEY_MASK;
    res.status = ST_OK;
    res.found  = 1'b0;
    res.data   = '0;
    hit        = -1;
    for (i = 0; i < model_fill; i++) begin
      if (model_keys[i] == key) hit = i;
    end
    case (op)
      REQ_PUSH: begin
        if (model_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_keys[model_fill] = key;
          model_fill++;
        end
      end
      REQ_POP: begin
        if (model_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = model_keys[model_fill-1];
          model_fill--;
        end
      end
      REQ_SEARCH: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else res.found = 1'b1;
      end
      default: begin
        // Drop the topmost match, entries above slide down
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.found = 1'b1;
          for (i = hit; i < model_fill - 1; i++) model_keys[i] = model_keys[i+1];
          model_fill--;
        end
      end
    endcase
    if (op != REQ_POP || res.status == ST_EMPTY) begin
      res.data = (model_fill == 0) ? 64'd0 : model_keys[model_fill-1];
    end
    res.occupancy = model_fill[3:0];
    return res;
  endfunction

  task automatic add_request(req_type_e op, logic [63:0] key);
    stack_request_t r;
    r.op  = op;
    r.key = key;
    pending_reqs.push_back(r);
  endtask

  // Request driver, falling edge
  always @(negedge clk_i) begin : drive_requests
    stack_request_t item;
    if (out_of_reset) begin
      if (!req_ch.valid || req_taken) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          item = pending_reqs.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= item.op;
          req_ch.key      <= item.key;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor, rising edge: predict on request, check on response
  always @(posedge clk_i) begin : watch_channels
    stack_result_t want;
    out_of_reset <= rst_ni;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      req_taken   <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(predict_stack(req_type_e'(req_ch.req_type), req_ch.key));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("response with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("status", rsp_ch.status, want.status);
          check_field("found", rsp_ch.found, want.found);
          check_field("data", rsp_ch.data, want.data);
          check_field("occupancy", rsp_ch.occupancy, want.occupancy);
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog on cycles with no handshake
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("stack_with_keyed_removal_unit: mismatch");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [63:0] key_pool [8];
    int          push_pct;
    int          roll;
    logic [63:0] key;
    req_type_e   op;

    rst_ni          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_PUSH;
    req_ch.key      = '0;
    rsp_ch.ready    = 1'b0;
    mismatches      = 0;
    cycle_count     = 0;
    stall_cycles    = 0;
    out_of_reset    = 1'b0;
    req_taken       = 1'b0;
    model_fill      = 0;

    // Directed: empty stack, fill to full, duplicates, removal at top,
    // middle and bottom, misses, drain past empty
    add_request(REQ_POP, 64'h0);
    add_request(REQ_SEARCH, 64'h5);
    add_request(REQ_REMOVE, 64'h5);
    add_request(REQ_PUSH, 64'h0);
    add_request(REQ_PUSH, {64{1'b1}});
    add_request(REQ_PUSH, 64'h5);
    add_request(REQ_PUSH, 64'h7);
    add_request(REQ_PUSH, 64'h5);
    add_request(REQ_PUSH, 64'h8000_0000_0000_0000);
    add_request(REQ_PUSH, 64'hA5A5_A5A5_A5A5_A5A5);
    add_request(REQ_PUSH, 64'h5A5A_5A5A_5A5A_5A5A);
    add_request(REQ_PUSH, 64'h9);
    add_request(REQ_SEARCH, 64'h5);
    add_request(REQ_SEARCH, 64'h3);
    add_request(REQ_REMOVE, 64'h5);
    add_request(REQ_REMOVE, 64'h0);
    add_request(REQ_REMOVE, 64'h5A5A_5A5A_5A5A_5A5A);
    add_request(REQ_REMOVE, 64'h3);
    add_request(REQ_SEARCH, 64'h5);
    add_request(REQ_POP, {64{1'b1}});
    add_request(REQ_POP, 64'h0);
    add_request(REQ_POP, 64'h0);
    add_request(REQ_POP, 64'h0);
    add_request(REQ_POP, 64'h0);
    add_request(REQ_POP, 64'h0);

    // Random: small key pool so searches and removals hit, plus full-range noise
    key_pool[0] = 64'h0;
    key_pool[1] = {64{1'b1}};
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      if ($urandom_range(0, 99) < 75) key = key_pool[$urandom_range(0, 7)];
      else key = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) op = req_type_e'($urandom_range(0, 3));
      else if (roll < push_pct) op = REQ_PUSH;
      else if (roll < push_pct + (100 - push_pct) / 2) op = REQ_POP;
      else if ($urandom_range(0, 1) == 0) op = REQ_SEARCH;
      else op = REQ_REMOVE;
      add_request(op, key);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() > 0 || req_ch.valid || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      flag_mismatch($sformatf("%0d responses never arrived", expected_results.size()));
    end

    if (mismatches == 0) begin
      $display("stack_with_keyed_removal_unit: match");
    end else begin
      $display("stack_with_keyed_removal_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/stkr_pkg.sv
hw/rtl/stkr_if.sv
hw/rtl/stkr_cell.sv
hw/rtl/stack_with_keyed_removal_unit.sv
hw/rtl/stkr_checker.sv
sim/testbench.sv
